// ----- design/mt64_pkg.sv -----
`timescale 1ns / 1ps

package mt64_pkg;

	localparam int STATE_WORDS  = 312;
	localparam int SHIFT_OFFSET = 156;
	localparam int ADDR_W       = $clog2(STATE_WORDS);

	localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(STATE_WORDS - 1);
	localparam logic [ADDR_W-1:0] SHIFT_ADDR = ADDR_W'(SHIFT_OFFSET);

	localparam logic [63:0] SEED_MULT   = 64'd6364136223846793005;
	localparam logic [63:0] TWIST_CONST = 64'hB502_6F5A_A966_19E9;
	localparam logic [63:0] HIGH_MASK   = 64'hFFFF_FFFF_8000_0000;
	localparam logic [63:0] LOW_MASK    = 64'h0000_0000_7FFF_FFFF;
	localparam logic [63:0] TEMPER_D    = 64'h5555_5555_5555_5555;
	localparam logic [63:0] TEMPER_B    = 64'h71D6_7FFF_EDA6_0000;
	localparam logic [63:0] TEMPER_C    = 64'hFFF7_EEE0_0000_0000;

	// One write into the state memory.
	typedef struct packed {
		logic              en;
		logic [ADDR_W-1:0] addr;
		logic [63:0]       data;
	} mt64_wr_t;

	// Seeding sequencer status toward the control logic.
	typedef struct packed {
		logic busy;
		logic first;
	} mt64_seed_stat_t;

	typedef enum logic [2:0] {
		SD_IDLE,
		SD_FIRST,
		SD_MUL_LL,
		SD_MUL_LH,
		SD_MUL_HL,
		SD_SUM
	} mt64_seed_state_t;

	typedef enum logic [1:0] {
		ST_SEED,
		ST_ISSUE,
		ST_RUN
	} mt64_state_t;

	function automatic logic [63:0] mt_mix(input logic [63:0] upper, input logic [63:0] lower,
		input logic [63:0] far);
		logic [63:0] y;
		logic [63:0] r;
		y = (upper & HIGH_MASK) | (lower & LOW_MASK);
		r = far ^ (y >> 1);
		if (y[0]) begin
			r = r ^ TWIST_CONST;
		end
		return r;
	endfunction

	function automatic logic [63:0] mt_temper(input logic [63:0] w);
		logic [63:0] x;
		x = w;
		x = x ^ ((x >> 29) & TEMPER_D);
		x = x ^ ((x << 17) & TEMPER_B);
		x = x ^ ((x << 37) & TEMPER_C);
		x = x ^ (x >> 43);
		return x;
	endfunction

endpackage

// ----- design/mt64_state_ram.sv -----
`timescale 1ns / 1ps

module mt64_state_ram import mt64_pkg::*; (
	input  logic              clk,
	input  mt64_wr_t          wr,
	input  logic              rd_en,
	input  logic [ADDR_W-1:0] ra_addr,
	input  logic [ADDR_W-1:0] rb_addr,
	output logic [63:0]       ra_data,
	output logic [63:0]       rb_data
);

	logic [63:0] mem [STATE_WORDS];
	logic [63:0] ra_data_q;
	logic [63:0] rb_data_q;

	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem[wr.addr] <= wr.data;
		end
	end

	// Read data holds until the next read so a stalled consumer keeps its operands.
	always_ff @(posedge clk) begin
		if (rd_en) begin
			ra_data_q <= mem[ra_addr];
			rb_data_q <= mem[rb_addr];
		end
	end

	assign ra_data = ra_data_q;
	assign rb_data = rb_data_q;

endmodule

// ----- design/mt64_seeder.sv -----
`timescale 1ns / 1ps

module mt64_seeder import mt64_pkg::*; (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	input  logic [63:0]     seed,
	output mt64_wr_t        wr,
	output mt64_seed_stat_t stat
);

	mt64_seed_state_t state_q, state_d;
	logic [ADDR_W-1:0] k_q;
	logic [63:0]       p_q;
	logic [63:0]       acc_q;
	logic [31:0]       cross_q;
	logic [63:0]       x;
	logic [31:0]       mul_a;
	logic [31:0]       mul_b;
	logic [63:0]       mul_p;
	logic [63:0]       sum;

	assign x     = p_q ^ (p_q >> 62);
	assign mul_p = 64'(mul_a) * 64'(mul_b);
	assign sum   = acc_q + {cross_q, 32'h0} + 64'(k_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= SD_FIRST;
			k_q     <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == SD_FIRST) begin
				k_q <= ADDR_W'(1);
			end else if (state_q == SD_SUM) begin
				k_q <= k_q + ADDR_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			SD_FIRST:  p_q     <= seed;
			SD_MUL_LL: acc_q   <= mul_p;
			SD_MUL_LH: cross_q <= mul_p[31:0];
			SD_MUL_HL: cross_q <= cross_q + mul_p[31:0];
			SD_SUM:    p_q     <= sum;
			default: ;
		endcase
	end

	// The low half of the product needs only three 32-bit partial products.
	always_comb begin
		state_d    = state_q;
		mul_a      = SEED_MULT[31:0];
		mul_b      = x[31:0];
		wr.en      = 1'b0;
		wr.addr    = k_q;
		wr.data    = sum;
		stat.busy  = 1'b1;
		stat.first = 1'b0;
		case (state_q)
			SD_IDLE: begin
				stat.busy = 1'b0;
				if (start) begin
					state_d = SD_FIRST;
				end
			end
			SD_FIRST: begin
				wr.en      = 1'b1;
				wr.addr    = '0;
				wr.data    = seed;
				stat.first = 1'b1;
				state_d    = SD_MUL_LL;
			end
			SD_MUL_LL: begin
				state_d = SD_MUL_LH;
			end
			SD_MUL_LH: begin
				mul_b   = x[63:32];
				state_d = SD_MUL_HL;
			end
			SD_MUL_HL: begin
				mul_a   = SEED_MULT[63:32];
				state_d = SD_SUM;
			end
			SD_SUM: begin
				wr.en   = 1'b1;
				state_d = (k_q == LAST_ADDR) ? SD_IDLE : SD_MUL_LL;
			end
			default: begin
				state_d = SD_IDLE;
			end
		endcase
	end

	seed_last_stop: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == SD_SUM && k_q == LAST_ADDR) |=> (state_q == SD_IDLE))
	else $error("seeding did not stop after the last word");

	seed_k_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != SD_IDLE && state_q != SD_FIRST) |-> (k_q != '0))
	else $error("seeding index wrapped to zero");

	seed_first_write: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == SD_FIRST) |=> (state_q == SD_MUL_LL && k_q == ADDR_W'(1)))
	else $error("seeding did not advance from the first word");

endmodule

// ----- design/mersenne_twister_64_generator.sv -----
`timescale 1ns / 1ps
// Latency: an accepted request registers the state memory read and the stage-1 valid,
// and the word is then registered onto out_valid; a restart request first reseeds, then draws its word.
// Throughput: one word per cycle while out_stall is low and no seeding runs, set by the two-port state memory read.
// Reset: arst_n clears control and starts seeding from seed 0,
// with in_stall high until seeding ends and the issue state has passed.
module mersenne_twister_64_generator import mt64_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [63:0] cfg_wdata,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        restart,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [63:0] random_word
);

	// The twist is done one word at a time as words are drawn. Drawing word k
	// reads the old w[k+1] and w[k+156 mod 312] from the memory; w[k] itself is
	// the "lower" operand of the previous draw, kept in upper_q, so two read
	// ports suffice. Because words are rewritten in order, the far operand and
	// the wrap to w[0] already see new values exactly where the batch twist does.

	mt64_state_t state_q, state_d;

	logic [63:0]       seed_q;
	logic [ADDR_W-1:0] pos_q;
	logic              s1_valid_s1;
	logic [ADDR_W-1:0] pos_s1;
	logic [63:0]       upper_q;
	logic              out_valid_q;
	logic [63:0]       out_word_q;
	logic              pend_q;

	logic              in_accept;
	logic              issue;
	logic              s1_adv;
	logic              seed_start;
	logic [ADDR_W-1:0] lower_addr;
	logic [ADDR_W-1:0] far_addr;
	logic [63:0]       lower_data;
	logic [63:0]       far_data;
	logic [63:0]       mixed;

	mt64_wr_t        seed_wr;
	mt64_wr_t        draw_wr;
	mt64_wr_t        ram_wr;
	mt64_seed_stat_t seed_stat;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seed_q <= '0;
		end else if (cfg_we) begin
			seed_q <= cfg_wdata;
		end
	end

	// A restart must not begin while a draw still has a write-back pending.
	// The issue state draws only for a restart request that is still waiting.
	assign s1_adv    = s1_valid_s1 && (!out_valid_q || !out_stall);
	assign in_stall  = (state_q != ST_RUN) || (s1_valid_s1 && !s1_adv)
		|| (restart && s1_valid_s1);
	assign in_accept = in_valid && !in_stall;
	assign issue     = (in_accept && !restart) || ((state_q == ST_ISSUE) && pend_q);

	assign lower_addr = (pos_q == LAST_ADDR) ? '0 : pos_q + ADDR_W'(1);
	assign far_addr   = (pos_q < SHIFT_ADDR) ? pos_q + SHIFT_ADDR : pos_q - SHIFT_ADDR;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_SEED;
			pos_q       <= '0;
			s1_valid_s1 <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (in_accept && restart) begin
				pos_q <= '0;
			end else if (issue) begin
				pos_q <= lower_addr;
			end
			if (issue) begin
				s1_valid_s1 <= 1'b1;
			end else if (s1_adv) begin
				s1_valid_s1 <= 1'b0;
			end
			if (s1_adv) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (issue) begin
			pos_s1 <= pos_q;
		end
		// The first seeded word is the upper operand of the first draw.
		if (seed_stat.first) begin
			upper_q <= seed_wr.data;
		end else if (s1_adv) begin
			upper_q <= lower_data;
		end
		if (s1_adv) begin
			out_word_q <= mt_temper(mixed);
		end
	end

	always_comb begin
		state_d    = state_q;
		seed_start = 1'b0;
		case (state_q)
			ST_SEED: begin
				if (!seed_stat.busy) begin
					state_d = ST_ISSUE;
				end
			end
			ST_ISSUE: begin
				state_d = ST_RUN;
			end
			ST_RUN: begin
				if (in_accept && restart) begin
					seed_start = 1'b1;
					state_d    = ST_SEED;
				end
			end
			default: begin
				state_d = ST_SEED;
			end
		endcase
	end

	// After reset there is no pending request, so the issue state must not draw.
	// A flag records whether seeding came from a restart request.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= 1'b0;
		end else if (in_accept && restart) begin
			pend_q <= 1'b1;
		end else if (state_q == ST_ISSUE) begin
			pend_q <= 1'b0;
		end
	end

	assign mixed = mt_mix(upper_q, lower_data, far_data);

	always_comb begin
		draw_wr.en   = s1_adv;
		draw_wr.addr = pos_s1;
		draw_wr.data = mixed;
		ram_wr       = seed_stat.busy ? seed_wr : draw_wr;
	end

	mt64_seeder u_seeder (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (seed_start),
		.seed   (seed_q),
		.wr     (seed_wr),
		.stat   (seed_stat)
	);

	mt64_state_ram u_ram (
		.clk     (clk),
		.wr      (ram_wr),
		.rd_en   (issue),
		.ra_addr (lower_addr),
		.rb_addr (far_addr),
		.ra_data (lower_data),
		.rb_data (far_data)
	);

	assign out_valid   = out_valid_q;
	assign random_word = out_word_q;

	seed_no_draw: assert property (@(posedge clk) disable iff (!arst_n)
		seed_stat.busy |-> !s1_valid_s1)
	else $error("draw write-back overlaps seeding");

	pos_range: assert property (@(posedge clk) disable iff (!arst_n)
		pos_q <= LAST_ADDR)
	else $error("draw position beyond the state store");

	restart_seeds: assert property (@(posedge clk) disable iff (!arst_n)
		(in_accept && restart) |=> (state_q == ST_SEED && seed_stat.busy && pos_q == '0))
	else $error("restart request did not start seeding");

	issue_pending: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_ISSUE) |-> (issue == pend_q))
	else $error("issue state drew without a pending request");

endmodule
